// ===== sv/scpf_pkg.sv =====
// Shared types, codes and constants for the servo command packet framer.
package scpf_pkg;

    // Command codes on the input channel.
    localparam logic [2:0] CMD_MOVE       = 3'd0;
    localparam logic [2:0] CMD_SET_ID     = 3'd1;
    localparam logic [2:0] CMD_SET_DEV    = 3'd2;
    localparam logic [2:0] CMD_TORQUE_OFF = 3'd3;
    localparam logic [2:0] CMD_TORQUE_ON  = 3'd4;
    localparam logic [2:0] CMD_READ_POS   = 3'd5;
    localparam logic [2:0] CMD_READ_DEV   = 3'd6;

    // Packet bytes.
    localparam logic [7:0] HDR0         = 8'h12;
    localparam logic [7:0] HDR1         = 8'h4C;
    localparam logic [7:0] BCAST_ID     = 8'hFE;
    localparam logic [7:0] INS_WRITE    = 8'h03;
    localparam logic [7:0] INS_READ     = 8'h02;
    localparam logic [7:0] INS_MOVE     = 8'h83;
    localparam logic [7:0] REG_POS      = 8'h2A;
    localparam logic [7:0] REG_ID       = 8'h05;
    localparam logic [7:0] REG_DEV      = 8'h14;
    localparam logic [7:0] REG_TORQUE   = 8'h28;
    localparam logic [7:0] REG_CUR_POS  = 8'h38;
    localparam logic [7:0] LEN_MOVE     = 8'h09;
    localparam logic [7:0] LEN_SHORT    = 8'h04;
    localparam logic [7:0] LEN_DEV      = 8'h05;
    localparam logic [7:0] MOVE_REGS    = 8'h04;
    localparam logic [7:0] READ_LEN     = 8'h02;

    // Index of the checksum byte for each packet kind.
    localparam logic [3:0] LAST_IDX_MOVE  = 4'd12;
    localparam logic [3:0] LAST_IDX_DEV   = 4'd8;
    localparam logic [3:0] LAST_IDX_SHORT = 4'd7;

    // Move commands to ids below this limit use the first port.
    localparam logic [7:0] FIRST_PORT_LIMIT = 8'd10;

    // Angle limits and the divisor of the scaling.
    localparam logic signed [9:0] ANGLE_MAX = 10'sd300;
    localparam int ANGLE_DIVISOR = 300;
    localparam int ANGLE_SPAN    = 600;

    localparam int POSITION_FULL_SCALE_DEFAULT = 4095;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MULT,
        ST_DIV,
        ST_SEND
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mul_en;
        logic div_step;
        logic send_step;
    } ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cmd_known;
        logic needs_div;
        logic out_free;
        logic at_last;
    } stat_t;

endpackage

// ===== sv/scpf_ctrl.sv =====
// Controller state machine of the servo command packet framer.
module scpf_ctrl
    import scpf_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    output logic   s_ready,
    input  stat_t  stat_i,
    output ctrl_t  ctrl_o
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && stat_i.cmd_known) begin
                    state_next = stat_i.needs_div ? ST_MULT : ST_SEND;
                end
            end
            ST_MULT: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                state_next = ST_SEND;
            end
            ST_SEND: begin
                if (stat_i.out_free && stat_i.at_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready          = 1'b0;
        ctrl_o           = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                ctrl_o.load = s_valid;
            end
            ST_MULT: begin
                ctrl_o.mul_en = 1'b1;
            end
            ST_DIV: begin
                ctrl_o.div_step = 1'b1;
            end
            ST_SEND: begin
                ctrl_o.send_step = stat_i.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== sv/scpf_datapath.sv =====
// Datapath of the servo command packet framer: scaling, reciprocal divide, byte mux, output register.
module scpf_datapath
    import scpf_pkg::*;
#(
    parameter int POSITION_FULL_SCALE = POSITION_FULL_SCALE_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  ctrl_t        ctrl_i,
    output stat_t        stat_o,
    input  logic [2:0]   s_cmd,
    input  logic [7:0]   s_servo_id,
    input  logic [9:0]   s_angle_value,
    input  logic [15:0]  s_move_time,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [7:0]   m_tx_byte,
    output logic         m_port_select,
    output logic         m_last_byte
);

    localparam int NUM_W = $clog2(ANGLE_SPAN * POSITION_FULL_SCALE + 1);
    // Rounded-up reciprocal of the divisor; the quotient is exact for every numerator
    // below 2**NUM_W.
    localparam int DIV_SHIFT = NUM_W + $clog2(ANGLE_DIVISOR);
    localparam longint unsigned DIV_RECIP =
        ((64'd1 << DIV_SHIFT) + 64'(ANGLE_DIVISOR) - 64'd1) / 64'(ANGLE_DIVISOR);
    localparam int PROD_W = 2 * NUM_W + 1;

    logic [2:0]        cmd_reg;
    logic [7:0]        id_reg;
    logic [15:0]       time_reg;
    logic [9:0]        scale_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [3:0]        idx_reg;
    logic [7:0]        sum_reg;
    logic              m_valid_reg;
    logic [7:0]        m_tx_byte_reg;
    logic              m_port_select_reg;
    logic              m_last_byte_reg;

    logic signed [9:0]  angle;
    logic signed [10:0] dev_clamp;
    logic signed [10:0] dev_sum;
    logic [9:0]         scale_next;
    logic [PROD_W-1:0]  quo_prod;
    logic [NUM_W-1:0]   quo;
    logic [NUM_W-1:0]   dev_full;
    logic [15:0]        value16;
    logic [3:0]         last_idx;
    logic [7:0]         byte_next;
    logic               port_next;

    // Scale input: clamped angle for a move, angle offset to 0..600 for a deviation.
    always_comb begin
        angle = $signed(s_angle_value);
        if (angle > ANGLE_MAX) begin
            dev_clamp = 11'(ANGLE_MAX);
        end else if (angle < -ANGLE_MAX) begin
            dev_clamp = -11'(ANGLE_MAX);
        end else begin
            dev_clamp = 11'(angle);
        end
        dev_sum = dev_clamp + 11'(ANGLE_MAX);
        if (s_cmd == CMD_MOVE) begin
            if (angle < 0) begin
                scale_next = '0;
            end else if (angle > ANGLE_MAX) begin
                scale_next = 10'(ANGLE_MAX);
            end else begin
                scale_next = $unsigned(angle);
            end
        end else begin
            scale_next = dev_sum[9:0];
        end
    end

    // Division by the constant divisor as a multiply by its reciprocal and a shift.
    assign quo_prod = PROD_W'(num_reg) * PROD_W'(DIV_RECIP);
    assign quo      = NUM_W'(quo_prod >> DIV_SHIFT);

    assign dev_full = num_reg - NUM_W'(POSITION_FULL_SCALE);
    assign value16  = (cmd_reg == CMD_MOVE) ? num_reg[15:0] : dev_full[15:0];
    assign port_next = (cmd_reg == CMD_MOVE) && (id_reg < FIRST_PORT_LIMIT);

    always_comb begin
        unique case (cmd_reg) inside
            CMD_MOVE:    last_idx = LAST_IDX_MOVE;
            CMD_SET_DEV: last_idx = LAST_IDX_DEV;
            default:     last_idx = LAST_IDX_SHORT;
        endcase
    end

    always_comb begin
        byte_next = 8'h00;
        if (idx_reg == last_idx) begin
            byte_next = ~sum_reg;
        end else if (idx_reg == 4'd0) begin
            byte_next = HDR0;
        end else if (idx_reg == 4'd1) begin
            byte_next = HDR1;
        end else begin
            unique case (cmd_reg) inside
                CMD_MOVE: begin
                    case (idx_reg)
                        4'd2:    byte_next = BCAST_ID;
                        4'd3:    byte_next = LEN_MOVE;
                        4'd4:    byte_next = INS_MOVE;
                        4'd5:    byte_next = REG_POS;
                        4'd6:    byte_next = MOVE_REGS;
                        4'd7:    byte_next = id_reg;
                        4'd8:    byte_next = value16[15:8];
                        4'd9:    byte_next = value16[7:0];
                        4'd10:   byte_next = time_reg[15:8];
                        default: byte_next = time_reg[7:0];
                    endcase
                end
                CMD_SET_ID: begin
                    case (idx_reg)
                        4'd2:    byte_next = BCAST_ID;
                        4'd3:    byte_next = LEN_SHORT;
                        4'd4:    byte_next = INS_WRITE;
                        4'd5:    byte_next = REG_ID;
                        default: byte_next = id_reg;
                    endcase
                end
                CMD_SET_DEV: begin
                    case (idx_reg)
                        4'd2:    byte_next = id_reg;
                        4'd3:    byte_next = LEN_DEV;
                        4'd4:    byte_next = INS_WRITE;
                        4'd5:    byte_next = REG_DEV;
                        4'd6:    byte_next = value16[15:8];
                        default: byte_next = value16[7:0];
                    endcase
                end
                CMD_TORQUE_OFF, CMD_TORQUE_ON: begin
                    case (idx_reg)
                        4'd2:    byte_next = id_reg;
                        4'd3:    byte_next = LEN_SHORT;
                        4'd4:    byte_next = INS_WRITE;
                        4'd5:    byte_next = REG_TORQUE;
                        default: byte_next = (cmd_reg == CMD_TORQUE_ON) ? 8'h01 : 8'h00;
                    endcase
                end
                default: begin
                    case (idx_reg)
                        4'd2:    byte_next = id_reg;
                        4'd3:    byte_next = LEN_SHORT;
                        4'd4:    byte_next = INS_READ;
                        4'd5:    byte_next = (cmd_reg == CMD_READ_POS) ? REG_CUR_POS : REG_DEV;
                        default: byte_next = READ_LEN;
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl_i.load) begin
            cmd_reg   <= s_cmd;
            id_reg    <= s_servo_id;
            time_reg  <= s_move_time;
            scale_reg <= scale_next;
        end
        if (ctrl_i.mul_en) begin
            num_reg <= NUM_W'(scale_reg) * NUM_W'(POSITION_FULL_SCALE);
        end else if (ctrl_i.div_step) begin
            num_reg <= quo;
        end
        if (ctrl_i.send_step) begin
            m_tx_byte_reg     <= byte_next;
            m_port_select_reg <= port_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg         <= '0;
            sum_reg         <= '0;
            m_valid_reg     <= 1'b0;
            m_last_byte_reg <= 1'b0;
        end else begin
            if (ctrl_i.load) begin
                idx_reg <= '0;
                sum_reg <= '0;
            end else if (ctrl_i.send_step) begin
                idx_reg <= idx_reg + 1'b1;
                if (idx_reg >= 4'd2) begin
                    sum_reg <= sum_reg + byte_next;
                end
            end
            if (ctrl_i.send_step) begin
                m_valid_reg     <= 1'b1;
                m_last_byte_reg <= (idx_reg == last_idx);
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        stat_o.cmd_known = (s_cmd <= CMD_READ_DEV);
        stat_o.needs_div = (s_cmd == CMD_MOVE) || (s_cmd == CMD_SET_DEV);
        stat_o.out_free  = !m_valid_reg || m_ready;
        stat_o.at_last   = (idx_reg == last_idx);
    end

    assign m_valid       = m_valid_reg;
    assign m_tx_byte     = m_tx_byte_reg;
    assign m_port_select = m_port_select_reg;
    assign m_last_byte   = m_last_byte_reg;

    // A new command is taken only after the previous packet has ended.
    a_load_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_i.load |-> (!m_valid_reg || m_last_byte_reg))
        else $error("command accepted in the middle of a packet");

    // Every packet opens with the first header byte.
    a_header_first: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_i.send_step && idx_reg == 4'd0 |=> m_tx_byte_reg == HDR0 && !m_last_byte_reg)
        else $error("packet does not start with the header");

    // The checksum byte is flagged as the end of the packet.
    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_i.send_step && idx_reg == last_idx |=> m_valid_reg && m_last_byte_reg)
        else $error("checksum byte not flagged as last");

    // The byte counter never runs past the longest packet.
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_i.send_step |-> idx_reg <= LAST_IDX_MOVE)
        else $error("byte index beyond packet length");

endmodule

// ===== sv/servo_command_packet_framer.sv =====
// Top level of the servo command packet framer.
//
// The input channel (s_valid/s_ready) takes one servo command: code, id,
// angle in degrees and move time. The output channel (m_valid/m_ready)
// gives the serial packet one byte per transfer, with the port select and
// a last flag on the closing checksum byte. Unknown command code 7 is
// accepted and gives no bytes.
// Move and deviation commands first scale the angle: a multiply by the
// full scale, then a divide by 300, done as a multiply by its reciprocal.
// The packet bytes then follow at one per cycle while the receiver is
// ready: 13 for move, 9 for deviation and 8 for the other commands.
// The next command is accepted once the last byte sits in the output
// register, even while that byte still waits for the receiver. A stalled
// receiver holds the output byte and pauses the packet.
// Reset (aresetn low, synchronous) returns to idle and drops any output.
module servo_command_packet_framer
    import scpf_pkg::*;
#(
    parameter int POSITION_FULL_SCALE = POSITION_FULL_SCALE_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [2:0]   s_cmd,
    input  logic [7:0]   s_servo_id,
    input  logic [9:0]   s_angle_value,
    input  logic [15:0]  s_move_time,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [7:0]   m_tx_byte,
    output logic         m_port_select,
    output logic         m_last_byte
);

    ctrl_t ctrl;
    stat_t stat;

    scpf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat_i  (stat),
        .ctrl_o  (ctrl)
    );

    scpf_datapath #(
        .POSITION_FULL_SCALE (POSITION_FULL_SCALE)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl_i        (ctrl),
        .stat_o        (stat),
        .s_cmd         (s_cmd),
        .s_servo_id    (s_servo_id),
        .s_angle_value (s_angle_value),
        .s_move_time   (s_move_time),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_tx_byte     (m_tx_byte),
        .m_port_select (m_port_select),
        .m_last_byte   (m_last_byte)
    );

endmodule
